// ===== hw/rtl/rsgr_pkg.sv =====
// Shared constants, codes and types for the range scan to grid rasteriser.
`default_nettype none

package rsgr_pkg;

  // Default geometry
  localparam int GRID_SIZE_DEF        = 32;
  localparam int CELL_MM_DEF          = 50;
  localparam int SENSOR_OFFSET_MM_DEF = 310;

  // Request commands
  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_START  = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_ANGLE_START = 2'd0;
  localparam logic [1:0] REG_ANGLE_STEP  = 2'd1;
  localparam logic [1:0] REG_RANGE_LOW   = 2'd2;
  localparam logic [1:0] REG_RANGE_HIGH  = 2'd3;

  // Quarter-wave polynomial coefficients, Q16
  localparam logic [16:0] SIN_A = 17'd102944;
  localparam logic [15:0] SIN_B = 16'd42048;
  localparam logic [12:0] SIN_C = 13'd4640;

  // Width of the signed cell numerators (Q15 millimetres)
  localparam int NUM_W = 36;

  // Output queue
  localparam int OUTQ_DEPTH = 16;
  localparam int OUTQ_AW    = 4;

  typedef struct packed {
    logic        hit;
    logic [4:0]  hit_row;
    logic [4:0]  hit_col;
    logic [31:0] row_bits;
  } result_t;

  // Phase within the quarter wave, mirrored on odd quadrants (0..16384)
  function automatic logic [14:0] fold_phase(input logic [15:0] a);
    logic [14:0] p;
    p = {1'b0, a[13:0]};
    if (a[14]) begin
      fold_phase = 15'(15'd16384 - p);
    end else begin
      fold_phase = p;
    end
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/range_scan_to_grid_rasterizer.sv =====
// Range scan to occupancy grid rasteriser: sine pipeline, cell index and bitmap RAM.
// A result passes through the pipeline stages and the output queue before it is offered.
// Throughput: one request per cycle while in_ready is high; the bitmap RAM does one read and one write a cycle,
// with the last write forwarded to a read of the same row.
// Up to 16 requests may be outstanding, bounded by the output queue.
// Reset: synchronous; resets the configuration registers, clears the running angle and all row valid bits (empty grid).
`default_nettype none

module range_scan_to_grid_rasterizer #(
  parameter int GRID_SIZE        = rsgr_pkg::GRID_SIZE_DEF,
  parameter int CELL_MM          = rsgr_pkg::CELL_MM_DEF,
  parameter int SENSOR_OFFSET_MM = rsgr_pkg::SENSOR_OFFSET_MM_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [15:0] range_mm,
  input  logic [4:0]  row_select,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        hit,
  output logic [4:0]  hit_row,
  output logic [4:0]  hit_col,
  output logic [31:0] row_bits
);

  localparam int RW = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
  localparam int NW = rsgr_pkg::NUM_W;
  localparam int QD = rsgr_pkg::OUTQ_DEPTH;
  localparam int QA = rsgr_pkg::OUTQ_AW;

  localparam longint CellQ = longint'(CELL_MM) * 32768;
  localparam logic signed [NW-1:0] HALF_CELL = NW'(CellQ);
  localparam logic signed [NW-1:0] GRID_CTR  = NW'(longint'(GRID_SIZE) * CellQ);
  localparam logic signed [NW-1:0] EDGE_LIM  = NW'(longint'(2 * GRID_SIZE - 1) * CellQ);
  localparam logic signed [NW-1:0] OFFSET_Q  = NW'(longint'(SENSOR_OFFSET_MM) * 32768);
  localparam logic [16:0] RECIP  = 17'(65536 / CELL_MM);
  localparam logic [9:0]  CELL_K = 10'(CELL_MM);

  typedef struct packed {
    logic [1:0]  cmd;
    logic [4:0]  sel;
    logic        sel_ok;
    logic        inr;
  } ctl_t;

  // Configuration registers
  logic [15:0] angle_start, angle_step, range_low, range_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_start <= '0;
      angle_step  <= '0;
      range_low   <= '0;
      range_high  <= 16'hFFFF;
    end else if (cfg_we) begin
      case (cfg_index)
        rsgr_pkg::REG_ANGLE_START: angle_start <= cfg_data;
        rsgr_pkg::REG_ANGLE_STEP:  angle_step  <= cfg_data;
        rsgr_pkg::REG_RANGE_LOW:   range_low   <= cfg_data;
        rsgr_pkg::REG_RANGE_HIGH:  range_high  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Request acceptance and credit count
  logic          accept, pop, push;
  logic [QA:0]   outstanding;
  logic [QA:0]   outq_count;

  assign in_ready = (outstanding < (QA+1)'(QD));
  assign accept   = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      case ({accept, pop})
        2'b10:   outstanding <= outstanding + 1'b1;
        2'b01:   outstanding <= outstanding - 1'b1;
        default: ;
      endcase
    end
  end

  // Running angle, advanced in request order
  logic [15:0] running_angle;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_angle <= '0;
    end else if (accept) begin
      if (command == rsgr_pkg::CMD_START) begin
        running_angle <= angle_start;
      end else if (command == rsgr_pkg::CMD_SAMPLE) begin
        running_angle <= running_angle + angle_step;
      end
    end
  end

  // Pipeline valid shift: vld[k] is stage k+1
  logic [9:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[8:0], accept};
    end
  end

  ctl_t s1_ctl, s2_ctl, s3_ctl, s4_ctl, s5_ctl, s6_ctl, s7_ctl, s8_ctl, s9_ctl, s10_ctl;

  always_ff @(posedge clk) begin
    s2_ctl  <= s1_ctl;
    s3_ctl  <= s2_ctl;
    s4_ctl  <= s3_ctl;
    s5_ctl  <= s4_ctl;
    s6_ctl  <= s5_ctl;
    s7_ctl  <= s6_ctl;
    s8_ctl  <= s7_ctl;
    s9_ctl  <= s8_ctl;
    s10_ctl <= s9_ctl;
  end

  // Stage 1: capture request and angle
  logic [15:0] s1_angle, s1_range;

  always_ff @(posedge clk) begin
    s1_angle      <= running_angle;
    s1_range      <= range_mm;
    s1_ctl.cmd    <= command;
    s1_ctl.sel    <= row_select;
    s1_ctl.sel_ok <= (7'(row_select) < 7'(GRID_SIZE));
    s1_ctl.inr    <= (range_mm > range_low) && (range_mm < range_high);
  end

  // Stage 2: fold phase, x squared (sine and cosine lanes)
  logic [15:0] cos_angle;
  logic [14:0] xs_c, xc_c;
  logic [29:0] sq_s, sq_c;
  logic [14:0] s2_xs, s2_xc, s2_x2s, s2_x2c;
  logic        s2_ns, s2_nc;
  logic [15:0] s2_range;

  assign cos_angle = s1_angle + 16'h4000;
  assign xs_c      = rsgr_pkg::fold_phase(s1_angle);
  assign xc_c      = rsgr_pkg::fold_phase(cos_angle);
  assign sq_s      = 30'(xs_c) * 30'(xs_c);
  assign sq_c      = 30'(xc_c) * 30'(xc_c);

  always_ff @(posedge clk) begin
    s2_xs    <= xs_c;
    s2_xc    <= xc_c;
    s2_ns    <= s1_angle[15];
    s2_nc    <= cos_angle[15];
    s2_x2s   <= sq_s[28:14];
    s2_x2c   <= sq_c[28:14];
    s2_range <= s1_range;
  end

  // Stage 3: t = B - x2*C
  logic [27:0] tc_s, tc_c;
  logic [14:0] s3_xs, s3_xc, s3_x2s, s3_x2c;
  logic [15:0] s3_ts, s3_tc;
  logic        s3_ns, s3_nc;
  logic [15:0] s3_range;

  assign tc_s = 28'(s2_x2s) * 28'(rsgr_pkg::SIN_C);
  assign tc_c = 28'(s2_x2c) * 28'(rsgr_pkg::SIN_C);

  always_ff @(posedge clk) begin
    s3_xs    <= s2_xs;
    s3_xc    <= s2_xc;
    s3_x2s   <= s2_x2s;
    s3_x2c   <= s2_x2c;
    s3_ns    <= s2_ns;
    s3_nc    <= s2_nc;
    s3_ts    <= rsgr_pkg::SIN_B - 16'(tc_s[27:14]);
    s3_tc    <= rsgr_pkg::SIN_B - 16'(tc_c[27:14]);
    s3_range <= s2_range;
  end

  // Stage 4: u = A - x2*t
  logic [30:0] uc_s, uc_c;
  logic [14:0] s4_xs, s4_xc;
  logic [16:0] s4_us, s4_uc;
  logic        s4_ns, s4_nc;
  logic [15:0] s4_range;

  assign uc_s = 31'(s3_x2s) * 31'(s3_ts);
  assign uc_c = 31'(s3_x2c) * 31'(s3_tc);

  always_ff @(posedge clk) begin
    s4_xs    <= s3_xs;
    s4_xc    <= s3_xc;
    s4_ns    <= s3_ns;
    s4_nc    <= s3_nc;
    s4_us    <= rsgr_pkg::SIN_A - uc_s[30:14];
    s4_uc    <= rsgr_pkg::SIN_A - uc_c[30:14];
    s4_range <= s3_range;
  end

  // Stage 5: f = x*u, saturate, apply quadrant sign
  logic [31:0] fp_s, fp_c;
  logic [14:0] mag_s, mag_c;
  logic signed [15:0] s5_sin, s5_cos;
  logic [15:0] s5_range;

  assign fp_s  = 32'(s4_xs) * 32'(s4_us);
  assign fp_c  = 32'(s4_xc) * 32'(s4_uc);
  assign mag_s = (fp_s[31:15] > 17'd32767) ? 15'h7FFF : fp_s[29:15];
  assign mag_c = (fp_c[31:15] > 17'd32767) ? 15'h7FFF : fp_c[29:15];

  always_ff @(posedge clk) begin
    s5_sin   <= s4_ns ? -$signed({1'b0, mag_s}) : $signed({1'b0, mag_s});
    s5_cos   <= s4_nc ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
    s5_range <= s4_range;
  end

  // Stage 6: Cartesian position in Q15 millimetres
  logic signed [32:0]   py, px;
  logic signed [NW-1:0] s6_y, s6_x;

  assign py = $signed({1'b0, s5_range}) * s5_sin;
  assign px = $signed({1'b0, s5_range}) * s5_cos;

  always_ff @(posedge clk) begin
    s6_y <= NW'(py);
    s6_x <= NW'(px) + OFFSET_Q;
  end

  // Stage 7: cell numerators, grid bounds, rounding offset
  logic signed [NW-1:0] num_r, num_c, rnd_r, rnd_c;
  logic [15:0] s7_vr, s7_vc;
  logic        s7_okr, s7_okc;

  assign num_r = GRID_CTR + (s6_y <<< 1);
  assign num_c = GRID_CTR - (s6_x <<< 1);
  assign rnd_r = num_r + HALF_CELL;
  assign rnd_c = num_c + HALF_CELL;

  always_ff @(posedge clk) begin
    s7_vr  <= rnd_r[31:16];
    s7_vc  <= rnd_c[31:16];
    s7_okr <= !num_r[NW-1] && (num_r < EDGE_LIM);
    s7_okc <= !num_c[NW-1] && (num_c < EDGE_LIM);
  end

  // Stage 8: quotient estimate by reciprocal
  logic [32:0]   rp_r, rp_c;
  logic [15:0]   s8_vr, s8_vc;
  logic [RW-1:0] s8_qr, s8_qc;
  logic          s8_hit;

  assign rp_r = 33'(s7_vr) * 33'(RECIP);
  assign rp_c = 33'(s7_vc) * 33'(RECIP);

  always_ff @(posedge clk) begin
    s8_vr  <= s7_vr;
    s8_vc  <= s7_vc;
    s8_qr  <= RW'(rp_r[32:16]);
    s8_qc  <= RW'(rp_c[32:16]);
    s8_hit <= (s7_ctl.cmd == rsgr_pkg::CMD_SAMPLE) && s7_ctl.inr && s7_okr && s7_okc;
  end

  // Stage 9: one-step quotient correction
  logic [16:0]   rem_r, rem_c;
  logic [RW-1:0] s9_row, s9_col, s9_addr;
  logic          s9_hit;

  assign rem_r = {1'b0, s8_vr} - 17'(17'(s8_qr) * 17'(CELL_K));
  assign rem_c = {1'b0, s8_vc} - 17'(17'(s8_qc) * 17'(CELL_K));

  always_ff @(posedge clk) begin
    s9_row <= (rem_r >= 17'(CELL_K)) ? RW'(s8_qr + 1'b1) : s8_qr;
    s9_col <= (rem_c >= 17'(CELL_K)) ? RW'(s8_qc + 1'b1) : s8_qc;
    s9_hit <= s8_hit;
  end

  // Bitmap RAM read address: marked row or selected row
  always_comb begin
    if (s9_hit) begin
      s9_addr = s9_row;
    end else if (s9_ctl.sel_ok) begin
      s9_addr = RW'(s9_ctl.sel);
    end else begin
      s9_addr = '0;
    end
  end

  // Bitmap RAM with registered read
  logic [GRID_SIZE-1:0] bitmap [GRID_SIZE];
  logic [GRID_SIZE-1:0] rdata;
  logic [GRID_SIZE-1:0] row_valid;
  logic [RW-1:0]        s10_addr, s10_col;
  logic                 s10_hit;
  logic                 wb_valid;
  logic [RW-1:0]        wb_addr;
  logic [GRID_SIZE-1:0] wb_data;
  logic [GRID_SIZE-1:0] base_row, new_row;
  logic                 do_write;
  logic                 do_clear;

  always_ff @(posedge clk) begin
    rdata    <= bitmap[s9_addr];
    s10_addr <= s9_addr;
    s10_col  <= s9_col;
    s10_hit  <= s9_hit;
  end

  // Stage 10: merge, forward the previous write, write back
  always_comb begin
    if (!row_valid[s10_addr]) begin
      base_row = '0;
    end else if (wb_valid && (wb_addr == s10_addr)) begin
      base_row = wb_data;
    end else begin
      base_row = rdata;
    end
  end

  assign new_row  = base_row | (GRID_SIZE'(1) << s10_col);
  assign do_write = vld[9] && s10_hit;
  assign do_clear = vld[9] && (s10_ctl.cmd == rsgr_pkg::CMD_START);

  always_ff @(posedge clk) begin
    if (do_write) begin
      bitmap[s10_addr] <= new_row;
    end
    wb_addr <= s10_addr;
    wb_data <= new_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      wb_valid  <= 1'b0;
    end else begin
      wb_valid <= do_write;
      if (do_clear) begin
        row_valid <= '0;
      end else if (do_write) begin
        row_valid[s10_addr] <= 1'b1;
      end
    end
  end

  // Result assembly
  rsgr_pkg::result_t res;

  always_comb begin
    res.hit      = s10_hit;
    res.hit_row  = s10_hit ? 5'(s10_addr) : 5'd0;
    res.hit_col  = s10_hit ? 5'(s10_col) : 5'd0;
    res.row_bits = ((s10_ctl.cmd == rsgr_pkg::CMD_READ) && s10_ctl.sel_ok) ?
                   32'(base_row) : 32'd0;
  end

  // Output queue
  rsgr_pkg::result_t outq [QD];
  logic [QA-1:0] wptr, rptr;

  assign push = vld[9];

  always_ff @(posedge clk) begin
    if (push) begin
      outq[wptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr       <= '0;
      rptr       <= '0;
      outq_count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   outq_count <= outq_count + 1'b1;
        2'b01:   outq_count <= outq_count - 1'b1;
        default: ;
      endcase
    end
  end

  assign out_valid = (outq_count != '0);
  assign hit       = outq[rptr].hit;
  assign hit_row   = outq[rptr].hit_row;
  assign hit_col   = outq[rptr].hit_col;
  assign row_bits  = outq[rptr].row_bits;

  // Checks
  a_hit_in_grid: assert property (@(posedge clk) disable iff (rst)
    (vld[8] && s9_hit) |-> ((int'(s9_row) < GRID_SIZE) && (int'(s9_col) < GRID_SIZE)))
    else $error("marked cell outside the grid");

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && !pop && (outq_count == (QA+1)'(QD))))
    else $error("output queue overflow");

  a_queue_within_credit: assert property (@(posedge clk) disable iff (rst)
    outq_count <= outstanding)
    else $error("queued results exceed outstanding requests");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    do_clear |=> (row_valid == '0))
    else $error("start request left rows marked");

endmodule

`default_nettype wire

// ===== dv/range_scan_to_grid_rasterizer_tb.sv =====
// Self-checking testbench for the range scan to occupancy grid rasteriser.
`timescale 1ns / 100ps

module range_scan_to_grid_rasterizer_tb;
  import rsgr_pkg::*;

  localparam int GRID = GRID_SIZE_DEF;
  localparam longint CELL_Q15 = longint'(CELL_MM_DEF) << 15;
  localparam longint OFFSET_Q15 = longint'(SENSOR_OFFSET_MM_DEF) << 15;
  // Quarter-wave polynomial coefficients, Q16
  localparam longint QW_A = 102944;
  localparam longint QW_B = 42048;
  localparam longint QW_C = 4640;
  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam int DRAIN_CYCLES = 24;
  localparam int STALL_CYCLES = 300;
  localparam longint TIMEOUT_NS = 4_000_000;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] range_mm;
    logic [4:0]  row_select;
  } scan_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_ANGLE_START;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  command = CMD_SAMPLE;
  logic [15:0] range_mm = '0;
  logic [4:0]  row_select = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        hit;
  logic [4:0]  hit_row;
  logic [4:0]  hit_col;
  logic [31:0] row_bits;

  // Predictor copy of the registers and the scan state
  logic [15:0] cfg_angle_start = '0;
  logic [15:0] cfg_angle_step = '0;
  logic [15:0] cfg_range_low = '0;
  logic [15:0] cfg_range_high = 16'hFFFF;
  logic [15:0] scan_angle = '0;
  logic [31:0] occupancy [GRID] = '{default: '0};

  scan_req_t scan_requests_q[$];
  result_t   raster_results_q[$];
  scan_req_t next_req;
  result_t   want;

  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stalls_requested = 0;
  int stalls_started = 0;
  int stall_left = 0;

  range_scan_to_grid_rasterizer dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .range_mm(range_mm),
    .row_select(row_select),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .hit(hit),
    .hit_row(hit_row),
    .hit_col(hit_col),
    .row_bits(row_bits)
  );

  always #10 clk = ~clk;

  // Quarter wave in Q15, x is a Q14 phase
  function automatic longint quarter_wave(input longint x);
    longint x2, t, u, f;
    x2 = (x * x) >> 14;
    t = QW_B - ((x2 * QW_C) >> 14);
    u = QW_A - ((x2 * t) >> 14);
    f = (x * u) >> 15;
    return (f > 32767) ? 32767 : f;
  endfunction

  // Sine of a binary angle, Q15
  function automatic longint sine_q15(input logic [15:0] a);
    longint p;
    p = longint'(a[13:0]);
    case (a[15:14])
      2'd0: return quarter_wave(p);
      2'd1: return quarter_wave(16384 - p);
      2'd2: return -quarter_wave(p);
      default: return -quarter_wave(16384 - p);
    endcase
  endfunction

  // Rounded cell index; false when the unrounded index is negative or the rounded index lies off the grid
  function automatic bit grid_cell(input longint num, output logic [4:0] idx);
    idx = '0;
    if (num < 0 || num >= (2 * GRID - 1) * CELL_Q15) return 1'b0;
    idx = 5'((num + CELL_Q15) / (2 * CELL_Q15));
    return 1'b1;
  endfunction

  // Applies one request to the predicted grid and returns its result
  function automatic result_t rasterize(input logic [1:0] cmd, input logic [15:0] rng,
                                        input logic [4:0] sel);
    result_t res;
    longint  sn, cs, y, x;
    logic [4:0] r_idx, c_idx;
    bit r_ok, c_ok;
    res = '0;
    case (cmd)
      CMD_START: begin
        for (int i = 0; i < GRID; i++) occupancy[i] = '0;
        scan_angle = cfg_angle_start;
      end
      CMD_READ: begin
        if (sel < GRID) res.row_bits = occupancy[sel];
      end
      CMD_SAMPLE: begin
        if (rng > cfg_range_low && rng < cfg_range_high) begin
          sn = sine_q15(scan_angle);
          cs = sine_q15(16'(scan_angle + 16'h4000));
          y = longint'(rng) * sn;
          x = longint'(rng) * cs + OFFSET_Q15;
          r_ok = grid_cell(GRID * CELL_Q15 + 2 * y, r_idx);
          c_ok = grid_cell(GRID * CELL_Q15 - 2 * x, c_idx);
          if (r_ok && c_ok) begin
            occupancy[r_idx][c_idx] = 1'b1;
            res.hit = 1'b1;
            res.hit_row = r_idx;
            res.hit_col = c_idx;
          end
        end
        scan_angle = 16'(scan_angle + cfg_angle_step);
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] got);
    if (exp_v !== got) begin
      $display("%0t: %s expected %h got %h", $time, name, exp_v, got);
      mismatch_count++;
    end
  endfunction

  function automatic void post_request(input logic [1:0] cmd, input logic [15:0] rng,
                                       input logic [4:0] sel);
    scan_req_t req;
    req.command = cmd;
    req.range_mm = rng;
    req.row_select = sel;
    scan_requests_q.insert(scan_requests_q.size(), req);
  endfunction

  // Mostly ranges that land on the grid, some at the limits, some anywhere
  function automatic logic [15:0] pick_range();
    int kind;
    kind = $urandom_range(99);
    if (kind < 75) return 16'($urandom_range(1, 1200));
    if (kind < 85) begin
      case ($urandom_range(3))
        0: return cfg_range_low;
        1: return 16'(cfg_range_low + 16'd1);
        2: return 16'(cfg_range_high - 16'd1);
        default: return cfg_range_high;
      endcase
    end
    return 16'($urandom);
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_ANGLE_START: cfg_angle_start = val;
      REG_ANGLE_STEP:  cfg_angle_step = val;
      REG_RANGE_LOW:   cfg_range_low = val;
      default:         cfg_range_high = val;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every request has been taken and answered, then lets the pipe settle
  task automatic wait_for_drain();
    while (scan_requests_q.size() != 0 || in_valid || raster_results_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        raster_results_q.insert(raster_results_q.size(),
                                rasterize(command, range_mm, row_select));
      end
      if (!in_valid || in_ready) begin
        if (scan_requests_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = scan_requests_q.pop_front();
          command <= next_req.command;
          range_mm <= next_req.range_mm;
          row_select <= next_req.row_select;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, so the block backs up into its input
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (stalls_started != stalls_requested) begin
      stall_left <= STALL_CYCLES;
      stalls_started <= stalls_started + 1;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (raster_results_q.size() == 0) begin
          $display("%0t: unexpected result hit %0d row %0d col %0d bits %h", $time,
                   hit, hit_row, hit_col, row_bits);
          mismatch_count++;
        end else begin
          want = raster_results_q.pop_front();
          check_field("hit", 32'(want.hit), 32'(hit));
          check_field("hit_row", 32'(want.hit_row), 32'(hit_row));
          check_field("hit_col", 32'(want.hit_col), 32'(hit_col));
          check_field("row_bits", want.row_bits, row_bits);
        end
      end
      if (stall_left != 0) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Stimulus
  initial begin
    int left;
    int burst;
    int kind;
    logic [15:0] a_start, a_step, r_low, r_high;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: angle stays at zero, limits exclude only 0 and 65535
    post_request(CMD_READ, 16'd0, 5'd16);
    post_request(CMD_SAMPLE, 16'd490, 5'd0);    // lands in column zero
    post_request(CMD_SAMPLE, 16'd491, 5'd0);    // just below zero, would round to it
    post_request(CMD_SAMPLE, 16'd0, 5'd0);      // on the low limit
    post_request(CMD_SAMPLE, 16'hFFFF, 5'd0);   // on the high limit
    post_request(CMD_READ, 16'd0, 5'd16);
    post_request(CMD_NOP, 16'hFFFF, 5'd31);
    post_request(CMD_READ, 16'd0, 5'd0);
    wait_for_drain();

    // Quarter turns: each edge of the grid, then one step past it
    write_reg(REG_ANGLE_START, 16'h0000);
    write_reg(REG_ANGLE_STEP, 16'h4000);
    post_request(CMD_START, 16'd0, 5'd0);
    post_request(CMD_SAMPLE, 16'd490, 5'd0);
    post_request(CMD_SAMPLE, 16'd775, 5'd0);
    post_request(CMD_SAMPLE, 16'd1085, 5'd0);
    post_request(CMD_SAMPLE, 16'd800, 5'd0);
    post_request(CMD_SAMPLE, 16'd491, 5'd0);
    post_request(CMD_SAMPLE, 16'd776, 5'd0);    // row would round to the grid size
    post_request(CMD_SAMPLE, 16'd1086, 5'd0);   // column would round to the grid size
    post_request(CMD_SAMPLE, 16'd801, 5'd0);
    post_request(CMD_READ, 16'd0, 5'd0);
    post_request(CMD_READ, 16'd0, 5'd16);
    post_request(CMD_READ, 16'd0, 5'd31);
    post_request(CMD_START, 16'd0, 5'd0);
    post_request(CMD_READ, 16'd0, 5'd16);

    // Random scans under a series of settings
    for (int ph = 0; ph < 7; ph++) begin
      wait_for_drain();
      case (ph)
        0, 1: begin
          send_idle_pct = 14;
          recv_idle_pct = 50;
        end
        2, 3: begin
          send_idle_pct = 50;
          recv_idle_pct = 14;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (ph)
        0: begin
          a_start = 16'($urandom);
          a_step = 16'($urandom_range(0, 4095));
          r_low = 16'h0000;
          r_high = 16'hFFFF;
        end
        1: begin
          a_start = 16'h8000;
          a_step = 16'h7FFF;
          r_low = 16'($urandom_range(0, 400));
          r_high = 16'($urandom_range(700, 1300));
        end
        2: begin
          a_start = 16'h7FFF;
          a_step = 16'h8000;
          r_low = 16'($urandom_range(0, 600));
          r_high = 16'($urandom_range(400, 2000));
        end
        3: begin
          a_start = 16'($urandom);
          a_step = 16'($urandom);
          r_low = 16'h0000;
          r_high = 16'($urandom);
        end
        4: begin
          a_start = 16'($urandom);
          a_step = 16'(-int'($urandom_range(1, 300)));
          r_low = 16'($urandom_range(0, 100));
          r_high = 16'hFFFF;
        end
        5: begin
          // nothing can pass these limits
          a_start = 16'($urandom);
          a_step = 16'($urandom);
          r_low = 16'hFFFF;
          r_high = 16'h0000;
        end
        default: begin
          a_start = 16'h0000;
          a_step = 16'($urandom_range(1, 2048));
          r_low = 16'($urandom_range(0, 300));
          r_high = 16'($urandom_range(900, 65535));
        end
      endcase
      write_reg(REG_ANGLE_START, a_start);
      write_reg(REG_ANGLE_STEP, a_step);
      write_reg(REG_RANGE_LOW, r_low);
      write_reg(REG_RANGE_HIGH, r_high);

      left = (ph == 5) ? 60 : 300;
      while (left > 0) begin
        post_request(CMD_START, 16'($urandom), 5'($urandom));
        left--;
        burst = $urandom_range(4, 48);
        for (int k = 0; k < burst && left > 0; k++) begin
          kind = $urandom_range(99);
          if (kind < 80) post_request(CMD_SAMPLE, pick_range(), 5'($urandom));
          else if (kind < 92) post_request(CMD_READ, 16'($urandom), 5'($urandom));
          else if (kind < 96) post_request(CMD_NOP, 16'($urandom), 5'($urandom));
          else post_request(CMD_START, 16'($urandom), 5'($urandom));
          left--;
        end
        // read back part of the finished scan
        burst = $urandom_range(2, 12);
        for (int k = 0; k < burst && left > 0; k++) begin
          post_request(CMD_READ, 16'($urandom), 5'($urandom));
          left--;
        end
      end
      if (ph == 1 || ph == 6) stalls_requested++;
    end

    wait_for_drain();
    if (mismatch_count == 0) begin
      $display("range_scan_to_grid_rasterizer_tb: clean");
    end else begin
      $display("range_scan_to_grid_rasterizer_tb: errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("range_scan_to_grid_rasterizer_tb: errors");
    $finish;
  end

endmodule
